FILE: hw/rtl/khsm_pkg.sv
package khsm_pkg;

   localparam int unsigned MAX_SLOT_BITS = 16;
   localparam int unsigned SLOT_W        = 16;
   localparam int unsigned CRC_W         = 32;
   localparam int unsigned SLOT_BITS_W   = 5;
   localparam int unsigned RSP_DATA_W    = SLOT_W + CRC_W;

   localparam logic [7:0]             OPEN_BRACE     = 8'h7B;
   localparam logic [7:0]             CLOSE_BRACE    = 8'h7D;
   localparam logic [CRC_W-1:0]       CRC_POLY       = 32'hEDB8_8320;
   localparam logic [CRC_W-1:0]       CRC_INIT       = 32'hFFFF_FFFF;
   localparam logic [SLOT_BITS_W-1:0] SLOT_BITS_INIT = 5'd10;

   // brace tracking phase
   typedef logic [1:0] phase_type;
   localparam phase_type PHASE_BEFORE = 2'd0;
   localparam phase_type PHASE_TAG    = 2'd1;
   localparam phase_type PHASE_AFTER  = 2'd2;

   typedef struct packed {
      logic [CRC_W-1:0] whole_crc;
      logic [CRC_W-1:0] tag_crc;
      phase_type        phase;
   } scan_type;

   localparam scan_type SCAN_INIT = '{whole_crc: CRC_INIT, tag_crc: CRC_INIT,
                                      phase: PHASE_BEFORE};

   // reflected crc-32, one byte, eight xor steps
   function automatic logic [CRC_W-1:0] crc32_byte(input logic [CRC_W-1:0] crc,
                                                   input logic [7:0] data);
      logic [CRC_W-1:0] c;
      c = crc ^ {{(CRC_W-8){1'b0}}, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // low-bit mask, width saturated to MAX_SLOT_BITS
   function automatic logic [SLOT_W-1:0] slot_mask(input logic [SLOT_BITS_W-1:0] bits);
      logic [SLOT_W-1:0] m;
      for (int i = 0; i < SLOT_W; i++) begin
         m[i] = (SLOT_BITS_W'(i) < bits) && (i < MAX_SLOT_BITS);
      end
      return m;
   endfunction

endpackage

FILE: hw/rtl/khsm_scan.sv
module khsm_scan (
   input  khsm_pkg::scan_type cur,
   input  logic [7:0]         key_byte,
   output khsm_pkg::scan_type nxt
);
   import khsm_pkg::*;

   always_comb begin
      nxt           = cur;
      nxt.whole_crc = crc32_byte(cur.whole_crc, key_byte);
      case (cur.phase)
         PHASE_BEFORE: begin
            if (key_byte == OPEN_BRACE) nxt.phase = PHASE_TAG;
         end
         PHASE_TAG: begin
            if (key_byte == CLOSE_BRACE) nxt.phase = PHASE_AFTER;
            else nxt.tag_crc = crc32_byte(cur.tag_crc, key_byte);
         end
         default: begin
            nxt.phase = cur.phase;
         end
      endcase
   end

endmodule

FILE: hw/rtl/key_hash_tag_slot_mapper.sv
// key hash slot mapper: key bytes stream in on req, one per transfer, with req_tlast on the
// final byte of each key (keys are at least one byte). a reflected crc-32 runs over the whole
// key and a second one over the hash tag, the bytes between the first '{' and the first '}'
// after it. on the final byte one result goes out on rsp: the tag crc if the tag closed (an
// empty tag counts, has_tag in rsp_tuser set), else the whole-key crc, plus the slot, the crc
// masked to slot_bits low bits (saturated at 16). the block takes one byte every cycle: a
// byte goes into an input register, the crc and brace update are combinational, and the
// result is registered in an output register. rate is bound only by the rsp side stalling.
// the user must write slot_bits (csr_we/csr_wdata) only while idle; the block does not check.
module key_hash_tag_slot_mapper (
   input  logic                               clock,
   input  logic                               reset,
   // config
   input  logic                               csr_we,
   input  logic [khsm_pkg::SLOT_BITS_W-1:0]   csr_wdata,   // slot_bits
   // key byte stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,   // key_byte
   input  logic                               req_tlast,   // last_byte
   // result stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [khsm_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // slot_index[15:0], key_crc[47:16]
   output logic                               rsp_tuser    // has_tag
);
   import khsm_pkg::*;

   logic [SLOT_BITS_W-1:0] slot_bits_ff;

   // input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // running per-key state
   scan_type   scan_ff;
   scan_type   scan_in;

   // output register
   logic                  out_valid_ff;
   logic [SLOT_W-1:0]     out_slot_ff;
   logic [CRC_W-1:0]      out_crc_ff;
   logic                  out_tag_ff;

   logic             out_free;
   logic             advance;
   logic             tag_hit;
   logic [CRC_W-1:0] result_crc;

   khsm_scan u_scan (
      .cur      (scan_ff),
      .key_byte (in_byte_ff),
      .nxt      (scan_in)
   );

   // output slot free when empty or being drained this cycle
   assign out_free   = !out_valid_ff || rsp_tready;
   // a non-final byte never needs the output slot
   assign advance    = in_valid_ff && (!in_last_ff || out_free);
   assign req_tready = !in_valid_ff || advance;

   assign tag_hit    = (scan_in.phase == PHASE_AFTER);
   assign result_crc = ~(tag_hit ? scan_in.tag_crc : scan_in.whole_crc);

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_bits_ff <= SLOT_BITS_INIT;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         scan_ff      <= SCAN_INIT;
      end else begin
         if (csr_we) slot_bits_ff <= csr_wdata;

         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end

         if (advance) begin
            // restart for the next key after the final byte
            scan_ff <= in_last_ff ? SCAN_INIT : scan_in;
         end

         if (advance && in_last_ff) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance && in_last_ff) begin
         out_crc_ff  <= result_crc;
         out_slot_ff <= result_crc[SLOT_W-1:0] & slot_mask(slot_bits_ff);
         out_tag_ff  <= tag_hit;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_crc_ff, out_slot_ff};
   assign rsp_tuser  = out_tag_ff;

   // a held result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |-> !(advance && in_last_ff))
      else $error("result overwritten while stalled");

   // per-key state restarts after the final byte
   a_key_restart: assert property (@(posedge clock) disable iff (reset)
      (advance && in_last_ff) |=> (scan_ff == SCAN_INIT))
      else $error("key state not restarted");

   // slot only carries bits of the crc
   a_slot_in_crc: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> ((out_slot_ff & ~out_crc_ff[SLOT_W-1:0]) == '0))
      else $error("slot bits outside crc");

endmodule
